// ===== hw/rtl/led_strip_pwm_slot_encoder_core_macros.svh =====
// assertion macros shared by the encoder rtl
// the clocking and reset names clk and rst_n are taken from the module that uses them
`ifndef LED_STRIP_PWM_SLOT_ENCODER_CORE_MACROS_SVH
`define LED_STRIP_PWM_SLOT_ENCODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold in the same cycle as its trigger
`define LSPSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define LSPSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSPSE_ASSERT_NOW(lbl, ante, cons, msg)

`define LSPSE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/lspse_pkg.sv =====
package lspse_pkg;

    // default matrix size
    localparam int DEFAULT_MATRIX_WIDTH  = 32;
    localparam int DEFAULT_MATRIX_HEIGHT = 1;

    // bit slots sent per led
    localparam int SLOTS_PER_LED = 24;
    localparam int SLOT_CNT_W    = 5;

    // register reset values
    localparam logic [7:0] ONE_COMPARE_RST  = 8'd69;
    localparam logic [7:0] ZERO_COMPARE_RST = 8'd34;
    localparam logic [7:0] IDLE_COMPARE_RST = 8'd0;
    localparam logic [3:0] RESET_SLOTS_RST  = 4'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_ONE_COMPARE  = 2'd0;
    localparam logic [1:0] REG_ZERO_COMPARE = 2'd1;
    localparam logic [1:0] REG_IDLE_COMPARE = 2'd2;
    localparam logic [1:0] REG_RESET_SLOTS  = 2'd3;

    // command function codes
    localparam logic FUNC_SET_COLOR = 1'b0;
    localparam logic FUNC_REFILL    = 1'b1;

    // input transaction
    typedef struct packed {
        logic        func;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [23:0] rgb;
        logic        half;
    } cmd_t;

    // result transaction
    typedef struct packed {
        logic [5:0] slot;
        logic [7:0] compare_value;
        logic       last;
    } result_t;

    // compare values handed to the slot unit
    typedef struct packed {
        logic [7:0] one_compare;
        logic [7:0] zero_compare;
        logic [7:0] idle_compare;
    } cmp_cfg_t;

    // load request from the sequencer to the slot unit
    typedef struct packed {
        logic        load;
        logic        idle;
        logic        half;
        logic [23:0] color;
    } slot_load_t;

    // reorder a color into wire order, first bit sent at the msb: green, red, blue
    function automatic logic [23:0] wire_order(input logic [23:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

endpackage

// ===== hw/rtl/led_strip_pwm_slot_encoder_core.sv =====
// WS2812-style bit slot encoder with a frame store of MATRIX_WIDTH x MATRIX_HEIGHT
// 24-bit colors. A command is taken when start is high and busy is low. A set-color
// command writes one color and returns to idle with no result. A refill command
// reads the frame store, then loads the bit shifter, then gives 24
// results on consecutive cycles, one per cycle with strobe high, last on the 24th.
// The receiver cannot stall: each result is on the ports for one cycle only. After
// reset the frame store is cleared one led per cycle with busy high; the config
// port is live during that pass.
`include "led_strip_pwm_slot_encoder_core_macros.svh"

module led_strip_pwm_slot_encoder_core
    import lspse_pkg::*;
#(
    parameter int MATRIX_WIDTH  = DEFAULT_MATRIX_WIDTH,
    parameter int MATRIX_HEIGHT = DEFAULT_MATRIX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output result_t     result,
    output logic        strobe,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LED_TOTAL = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int ADDR_W    = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
    localparam int PTR_W     = $clog2(LED_TOTAL + 16);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [7:0]        one_cmp_reg;
    logic [7:0]        zero_cmp_reg;
    logic [7:0]        idle_cmp_reg;
    logic [3:0]        slots_reg;

    logic              accept;
    logic              cfg_wr;
    logic [16:0]       lin_addr;
    logic              in_range;
    logic              ptr_idle;
    logic [PTR_W:0]    ptr_inc;
    logic [PTR_W:0]    ptr_limit;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [23:0]       wr_data;
    logic              rd_en;
    logic [23:0]       rd_data;
    slot_load_t        ld;
    cmp_cfg_t          cmp_cfg;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_cmp_reg  <= ONE_COMPARE_RST;
            zero_cmp_reg <= ZERO_COMPARE_RST;
            idle_cmp_reg <= IDLE_COMPARE_RST;
            slots_reg    <= RESET_SLOTS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ONE_COMPARE:  one_cmp_reg  <= pwdata[7:0];
                REG_ZERO_COMPARE: zero_cmp_reg <= pwdata[7:0];
                REG_IDLE_COMPARE: idle_cmp_reg <= pwdata[7:0];
                REG_RESET_SLOTS:  slots_reg    <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ONE_COMPARE:  prdata = {24'd0, one_cmp_reg};
            REG_ZERO_COMPARE: prdata = {24'd0, zero_cmp_reg};
            REG_IDLE_COMPARE: prdata = {24'd0, idle_cmp_reg};
            REG_RESET_SLOTS:  prdata = {28'd0, slots_reg};
            default:          prdata = '0;
        endcase
    end

    // led address of a set-color command
    assign lin_addr = 17'(cmd_reg.col) + 17'(cmd_reg.row) * 17'(MATRIX_WIDTH);
    assign in_range = (9'(cmd_reg.col) < 9'(MATRIX_WIDTH))
                   && (9'(cmd_reg.row) < 9'(MATRIX_HEIGHT));

    // led pointer step and wrap after the idle refills
    assign ptr_idle  = (ptr_reg >= PTR_W'(LED_TOTAL));
    assign ptr_inc   = (PTR_W + 1)'(ptr_reg) + 1'b1;
    assign ptr_limit = (PTR_W + 1)'(LED_TOTAL) + (PTR_W + 1)'(slots_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ptr_next   = ptr_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = (cmd.func == FUNC_REFILL) ? ST_READ : ST_WRITE;
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(LED_TOTAL - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                ptr_next   = (ptr_inc >= ptr_limit) ? '0 : ptr_inc[PTR_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (strobe && result.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // frame store ports: clearing pass or color write, pointer read
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = (state_reg == ST_WRITE) && in_range;
            wr_addr = lin_addr[ADDR_W-1:0];
            wr_data = cmd_reg.rgb;
        end
    end

    assign rd_en = (state_reg == ST_READ) && !ptr_idle;

    lspse_frame_store #(
        .DEPTH  (LED_TOTAL),
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // bit shifter load
    always_comb
    begin
        ld.load  = (state_reg == ST_LOAD);
        ld.idle  = ptr_idle;
        ld.half  = cmd_reg.half;
        ld.color = ptr_idle ? 24'd0 : rd_data;
    end

    assign cmp_cfg.one_compare  = one_cmp_reg;
    assign cmp_cfg.zero_compare = zero_cmp_reg;
    assign cmp_cfg.idle_compare = idle_cmp_reg;

    lspse_slot_unit u_slot_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (ld),
        .cfg    (cmp_cfg),
        .result (result),
        .strobe (strobe)
    );

    // checks
    `LSPSE_ASSERT_NOW(a_strobe_in_emit, strobe, state_reg == ST_EMIT, "result outside emit")
    `LSPSE_ASSERT_NEXT(a_run_contiguous, strobe && !result.last, strobe, "result run broken")
    `LSPSE_ASSERT_NEXT(a_last_ends, strobe && result.last, state_reg == ST_IDLE && !strobe, "no return to idle after last slot")
    `LSPSE_ASSERT_NEXT(a_refill_reads, accept && cmd.func == FUNC_REFILL, state_reg == ST_READ, "refill did not start a read")

endmodule

// ===== hw/rtl/lspse_frame_store.sv =====
module lspse_frame_store
    import lspse_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MATRIX_WIDTH * DEFAULT_MATRIX_HEIGHT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [23:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [23:0]       rd_data
);

    logic [23:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/lspse_slot_unit.sv =====
module lspse_slot_unit
    import lspse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_load_t ld,
    input  cmp_cfg_t   cfg,
    output result_t    result,
    output logic       strobe
);

    logic [23:0]           shift_reg;
    logic [23:0]           shift_next;
    logic [SLOT_CNT_W-1:0] cnt_reg;
    logic [SLOT_CNT_W-1:0] cnt_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  idle_reg;
    logic                  idle_next;
    logic                  half_reg;
    logic                  half_next;
    logic                  at_end;

    assign at_end = (cnt_reg == SLOT_CNT_W'(SLOTS_PER_LED - 1));

    // load a color, then shift one bit out per cycle
    always_comb
    begin
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        idle_next   = idle_reg;
        half_next   = half_reg;
        if (ld.load)
        begin
            shift_next  = wire_order(ld.color);
            cnt_next    = '0;
            active_next = 1'b1;
            idle_next   = ld.idle;
            half_next   = ld.half;
        end
        else if (active_reg)
        begin
            shift_next = {shift_reg[22:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (at_end)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        idle_reg  <= idle_next;
        half_reg  <= half_next;
    end

    // compare select and slot position
    always_comb
    begin
        result.slot = half_reg ? (6'(SLOTS_PER_LED) + 6'(cnt_reg)) : 6'(cnt_reg);
        if (idle_reg)
        begin
            result.compare_value = cfg.idle_compare;
        end
        else if (shift_reg[23])
        begin
            result.compare_value = cfg.one_compare;
        end
        else
        begin
            result.compare_value = cfg.zero_compare;
        end
        result.last = at_end;
    end

    assign strobe = active_reg;

endmodule

// ===== test/led_strip_pwm_slot_encoder_core_tb.sv =====
module led_strip_pwm_slot_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lspse_pkg::*;

    localparam int MATRIX_W = DEFAULT_MATRIX_WIDTH;
    localparam int MATRIX_H = DEFAULT_MATRIX_HEIGHT;
    localparam int LED_NUM  = MATRIX_W * MATRIX_H;

    // frame store and led pointer mirror, expected slot results in arrival order
    class slot_scoreboard;
        logic [23:0]  colors [LED_NUM];
        int unsigned  led_ptr;
        logic [7:0]   one_cmp;
        logic [7:0]   zero_cmp;
        logic [7:0]   idle_cmp;
        logic [3:0]   latch_refills;
        result_t      due_slots [$];
        int           errors;

        function new();
            foreach (colors[i])
            begin
                colors[i] = '0;
            end
            led_ptr       = 0;
            one_cmp       = ONE_COMPARE_RST;
            zero_cmp      = ZERO_COMPARE_RST;
            idle_cmp      = IDLE_COMPARE_RST;
            latch_refills = RESET_SLOTS_RST;
            errors        = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] word);
            case (idx)
                REG_ONE_COMPARE:  one_cmp = word[7:0];
                REG_ZERO_COMPARE: zero_cmp = word[7:0];
                REG_IDLE_COMPARE: idle_cmp = word[7:0];
                REG_RESET_SLOTS:  latch_refills = word[3:0];
                default: ;
            endcase
        endfunction

        // an accepted command: paint one led, or queue the 24 slots of a refill
        function void take_command(cmd_t c);
            int unsigned pos;
            int unsigned src;
            logic [23:0] color;
            logic        idle;
            result_t     r;
            if (c.func == FUNC_SET_COLOR)
            begin
                if (c.col < MATRIX_W && c.row < MATRIX_H)
                begin
                    colors[c.col + c.row * MATRIX_W] = c.rgb;
                end
                return;
            end
            idle  = (led_ptr >= LED_NUM);
            color = '0;
            if (!idle)
            begin
                color = colors[led_ptr];
            end
            for (pos = 0; pos < SLOTS_PER_LED; pos++)
            begin
                // green byte, then red, then blue, each msb first
                if (pos < 8)
                    src = 15 - pos;
                else if (pos < 16)
                    src = 23 - (pos - 8);
                else
                    src = 7 - (pos - 16);
                r.slot          = 6'(c.half * SLOTS_PER_LED + pos);
                r.compare_value = idle ? idle_cmp : (color[src] ? one_cmp : zero_cmp);
                r.last          = (pos == SLOTS_PER_LED - 1);
                due_slots.push_back(r);
            end
            led_ptr++;
            if (led_ptr >= LED_NUM + latch_refills)
            begin
                led_ptr = 0;
            end
        endfunction

        function void check_slot(result_t got);
            result_t want;
            if (due_slots.size() == 0)
            begin
                $display("%0t: unexpected slot result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_slots.pop_front();
            if (got.slot !== want.slot)
            begin
                $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                errors++;
            end
            if (got.compare_value !== want.compare_value)
            begin
                $display("%0t: compare_value (slot %0d) expected %0d actual %0d",
                         $time, want.slot, want.compare_value, got.compare_value);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last (slot %0d) expected %0b actual %0b",
                         $time, want.slot, want.last, got.last);
                errors++;
            end
        endfunction

        function void close_out();
            if (due_slots.size() != 0)
            begin
                $display("%0t: %0d slot results never arrived", $time, due_slots.size());
                errors += due_slots.size();
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    result_t     result;
    logic        strobe;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slot_scoreboard sb;
    int             idle_pct;

    led_strip_pwm_slot_encoder_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .result  (result),
        .strobe  (strobe),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sample both sides at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                sb.check_slot(result);
            if (start && !busy)
                sb.take_command(cmd);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("led_strip_pwm_slot_encoder_core_tb: done, errors");
        $finish;
    end

    // register write: setup then access cycle, upper data bits random
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] word;
        word      = $urandom;
        word[7:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // one command transaction, called and returning at a falling edge
    task automatic issue(input cmd_t c);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 32);
            start <= 1'b0;
            // idle only while the block could take a command
            while (busy) @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // hold off until every slot has come and the block is idle
    task automatic settle();
        start <= 1'b0;
        while (sb.due_slots.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    function automatic cmd_t make_refill(input logic half);
        cmd_t c;
        c.func = FUNC_REFILL;
        c.col  = 8'($urandom_range(0, 255));
        c.row  = 8'($urandom_range(0, 255));
        c.rgb  = 24'($urandom_range(0, 24'hFFFFFF));
        c.half = half;
        return c;
    endfunction

    function automatic cmd_t make_paint(input logic [7:0] x, input logic [7:0] y,
                                        input logic [23:0] rgb);
        cmd_t c;
        c.func = FUNC_SET_COLOR;
        c.col  = x;
        c.row  = y;
        c.rgb  = rgb;
        c.half = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // mostly in-range paints and refills, some off-matrix writes
    function automatic cmd_t random_cmd();
        cmd_t c;
        if ($urandom_range(0, 99) < 55)
        begin
            c = make_refill(1'($urandom_range(0, 1)));
        end
        else
        begin
            c = make_paint(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           24'($urandom_range(0, 24'hFFFFFF)));
            if ($urandom_range(0, 99) < 80)
            begin
                c.col = 8'($urandom_range(0, MATRIX_W - 1));
                c.row = 8'($urandom_range(0, MATRIX_H - 1));
            end
        end
        return c;
    endfunction

    task automatic run_random(input int count);
        repeat (count) issue(random_cmd());
    endtask

    // refill until the led pointer sits at target
    task automatic advance_to(input int unsigned target);
        while (sb.led_ptr != target) issue(make_refill(1'($urandom_range(0, 1))));
    endtask

    task automatic random_regs(input logic [3:0] refills);
        write_reg(REG_ONE_COMPARE, 8'($urandom_range(0, 255)));
        write_reg(REG_ZERO_COMPARE, 8'($urandom_range(0, 255)));
        write_reg(REG_IDLE_COMPARE, 8'($urandom_range(0, 255)));
        write_reg(REG_RESET_SLOTS, {4'd0, refills});
    endtask

    // stimulus
    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 14;
        sb       = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset values written back while the frame store clears
        write_reg(REG_ONE_COMPARE, ONE_COMPARE_RST);
        write_reg(REG_ZERO_COMPARE, ZERO_COMPARE_RST);
        write_reg(REG_IDLE_COMPARE, IDLE_COMPARE_RST);
        write_reg(REG_RESET_SLOTS, {4'd0, RESET_SLOTS_RST});

        // directed: cleared led, single-bit colors per byte, off-matrix writes
        issue(make_refill(1'b0));
        issue(make_paint(8'd1, 8'd0, 24'h008000));
        issue(make_paint(8'd2, 8'd0, 24'h800000));
        issue(make_paint(8'd3, 8'd0, 24'h000080));
        issue(make_paint(8'd4, 8'd0, 24'hFFFFFF));
        issue(make_paint(8'd5, 8'd0, 24'h000000));
        issue(make_paint(8'(MATRIX_W), 8'd0, 24'hFFFFFF));
        issue(make_paint(8'd1, 8'(MATRIX_H), 24'h123456));
        issue(make_paint(8'd255, 8'd255, 24'hFFFFFF));
        issue(make_paint(8'(MATRIX_W - 1), 8'd0, 24'hA5A5A5));
        issue(make_paint(8'd0, 8'd0, 24'h5A5A5A));
        issue(make_refill(1'b1));
        issue(make_refill(1'b0));
        issue(make_refill(1'b1));
        issue(make_refill(1'b0));
        issue(make_refill(1'b1));
        settle();

        // extremes, no latch refills: wrap straight after the last led
        write_reg(REG_ONE_COMPARE, 8'hFF);
        write_reg(REG_ZERO_COMPARE, 8'h00);
        write_reg(REG_IDLE_COMPARE, 8'hFF);
        write_reg(REG_RESET_SLOTS, 8'd0);
        run_random(50);
        advance_to(LED_NUM - 1);
        issue(make_refill(1'b1));
        settle();

        // opposite extremes, longest latch
        write_reg(REG_ONE_COMPARE, 8'h00);
        write_reg(REG_ZERO_COMPARE, 8'hFF);
        write_reg(REG_IDLE_COMPARE, 8'h00);
        write_reg(REG_RESET_SLOTS, 8'd15);
        run_random(50);
        settle();

        // back to back with no idling, latch of one refill
        idle_pct = 0;
        random_regs(4'd1);
        run_random(60);
        settle();
        idle_pct = 14;

        // latch length lowered while the pointer is deep in the idle refills
        write_reg(REG_RESET_SLOTS, 8'd15);
        advance_to(LED_NUM + 12);
        settle();
        write_reg(REG_RESET_SLOTS, 8'd5);
        issue(make_refill(1'b0));
        issue(make_refill(1'b1));
        settle();

        repeat (4)
        begin
            random_regs(4'($urandom_range(0, 15)));
            run_random(35);
            settle();
        end

        repeat (30) @(negedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("led_strip_pwm_slot_encoder_core_tb: done, clean");
        else
            $display("led_strip_pwm_slot_encoder_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== led_strip_pwm_slot_encoder_core.f =====
+incdir+hw/rtl
hw/rtl/lspse_pkg.sv
hw/rtl/lspse_frame_store.sv
hw/rtl/lspse_slot_unit.sv
hw/rtl/led_strip_pwm_slot_encoder_core.sv
test/led_strip_pwm_slot_encoder_core_tb.sv
